@@ src/isr_pkg.sv @@
// ----------------------------------------------------------------------------
// isr_pkg: shared types and constants of the record insertion sorter
// Record, request and store access types, and the store sizing.
// ----------------------------------------------------------------------------
package isr_pkg;

  localparam int MaxRecords = 64;
  localparam int IdxW       = $clog2(MaxRecords);
  localparam int CntW       = IdxW + 1;
  localparam int KeyW       = 16;
  localparam int IdW        = 16;
  localparam int CmpW       = 11;

  localparam logic [CmpW-1:0] CmpMax = {CmpW{1'b1}};

  typedef struct packed {
    logic [KeyW-1:0] sort_key;
    logic [IdW-1:0]  record_id;
    logic            final_item;
  } in_req_t;

  typedef struct packed {
    logic [KeyW-1:0] sorted_key;
    logic [IdW-1:0]  sorted_id;
    logic [CmpW-1:0] comparison_total;
    logic            end_of_run;
  } out_req_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [IdW-1:0]  id;
  } rec_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    rec_t            wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } store_req_t;

endpackage

@@ src/isr_store.sv @@
// ----------------------------------------------------------------------------
// isr_store: record memory
// One write port and one read port; read data registered, held between reads.
// ----------------------------------------------------------------------------
module isr_store (
  input  logic               clk_i,
  input  isr_pkg::store_req_t req_i,
  output isr_pkg::rec_t      rdata_o
);

  isr_pkg::rec_t mem [isr_pkg::MaxRecords];
  isr_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/isr_out_reg.sv @@
// ----------------------------------------------------------------------------
// isr_out_reg: output request register
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module isr_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  isr_pkg::out_req_t data_i,
  input  logic              stall_i,
  output logic              valid_o,
  output isr_pkg::out_req_t req_o,
  output logic              free_o
);

  logic              valid_q;
  isr_pkg::out_req_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  // Free when empty or when the held request leaves this cycle.
  assign free_o  = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign req_o   = data_q;

endmodule

@@ src/insertion_sort_records_unit.sv @@
// ----------------------------------------------------------------------------
// insertion_sort_records_unit: stable insertion sorter for keyed records
// Inserts each incoming record into a sorted record memory and, at list end,
// streams the whole sorted list out with the comparison total.
// ----------------------------------------------------------------------------
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+--------------------------
//   input   | in_valid_i  | in_stall_o  | in_req_i  (in_req_t)
//   output  | out_valid_o | out_stall_i | out_req_o (out_req_t)
//
// Insertion: each insertion into a store of n records shifts s stored records
//   up (s in 0..n); the scan reads one memory entry and writes one back per
//   cycle through the single read port.
// Emission reads the stored records from entry 0 upward into the output register.
// Reset clears the record count, comparison count and control; the memory
//   itself is not cleared, and only entries below the count are ever read.
// Output stalls pause emission; the input is stalled whenever not idle.
// ----------------------------------------------------------------------------
module insertion_sort_records_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  isr_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output isr_pkg::out_req_t out_req_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_EMIT_START,
    S_EMIT_WAIT
  } state_e;

  state_e                        state_q, state_d;
  logic [isr_pkg::IdxW-1:0]      pos_q, pos_d;
  logic [isr_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [isr_pkg::CmpW-1:0]      cmp_q, cmp_d;
  logic [isr_pkg::IdxW-1:0]      idx_q, idx_d;
  isr_pkg::in_req_t              in_q, in_d;

  isr_pkg::store_req_t st_req;
  isr_pkg::rec_t       rd_data;
  isr_pkg::rec_t       new_rec;
  isr_pkg::out_req_t   out_data;
  logic                out_load;
  logic                out_free;
  logic                last_entry;
  logic [isr_pkg::CntW-1:0] cnt_inc;

  isr_store u_store (
    .clk_i   (clk_i),
    .req_i   (st_req),
    .rdata_o (rd_data)
  );

  isr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .data_i  (out_data),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .req_o   (out_req_o),
    .free_o  (out_free)
  );

  assign new_rec    = '{key: in_q.sort_key, id: in_q.record_id};
  assign cnt_inc    = cnt_q + isr_pkg::CntW'(1);
  // The entry in the read register is the last one of the list.
  assign last_entry = (isr_pkg::CntW'(idx_q) + isr_pkg::CntW'(1)) == cnt_q;
  assign out_data   = '{sorted_key:       rd_data.key,
                        sorted_id:        rd_data.id,
                        comparison_total: cmp_q,
                        end_of_run:       last_entry};

  // Take a new request only between lists and insertions.
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    cmp_d    = cmp_q;
    idx_d    = idx_q;
    in_d     = in_q;
    st_req   = '0;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d  = in_req_i;
          // Count is below the store depth here, so it fits the index.
          pos_d = cnt_q[isr_pkg::IdxW-1:0];
          if (cnt_q == '0) begin
            state_d = S_PLACE;
          end else begin
            // Fetch the last stored entry for the first comparison.
            st_req.re    = 1'b1;
            st_req.raddr = cnt_q[isr_pkg::IdxW-1:0] - isr_pkg::IdxW'(1);
            state_d      = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Entry pos-1 sits in the read register: count one comparison.
        if (cmp_q != isr_pkg::CmpMax) begin
          cmp_d = cmp_q + isr_pkg::CmpW'(1);
        end
        if (rd_data.key > in_q.sort_key) begin
          // Shift the larger entry up one place; keep scanning down unless it was entry 0.
          st_req.we    = 1'b1;
          st_req.waddr = pos_q;
          st_req.wdata = rd_data;
          pos_d        = pos_q - isr_pkg::IdxW'(1);
          if (pos_q == isr_pkg::IdxW'(1)) begin
            state_d = S_PLACE;
          end else begin
            st_req.re    = 1'b1;
            st_req.raddr = pos_q - isr_pkg::IdxW'(2);
          end
        end else begin
          // Equal or smaller key: drop the new record in above it.
          st_req.we    = 1'b1;
          st_req.waddr = pos_q;
          st_req.wdata = new_rec;
          cnt_d        = cnt_inc;
          state_d      = (in_q.final_item || cnt_inc == isr_pkg::CntW'(isr_pkg::MaxRecords))
                         ? S_EMIT_START : S_IDLE;
        end
      end

      S_PLACE: begin
        st_req.we    = 1'b1;
        st_req.waddr = pos_q;
        st_req.wdata = new_rec;
        cnt_d        = cnt_inc;
        state_d      = (in_q.final_item || cnt_inc == isr_pkg::CntW'(isr_pkg::MaxRecords))
                       ? S_EMIT_START : S_IDLE;
      end

      S_EMIT_START: begin
        st_req.re    = 1'b1;
        st_req.raddr = '0;
        idx_d        = '0;
        state_d      = S_EMIT_WAIT;
      end

      S_EMIT_WAIT: begin
        // Hold the read register until the output slot frees up.
        if (out_free) begin
          out_load = 1'b1;
          if (last_entry) begin
            cnt_d   = '0;
            cmp_d   = '0;
            state_d = S_IDLE;
          end else begin
            st_req.re    = 1'b1;
            st_req.raddr = idx_q + isr_pkg::IdxW'(1);
            idx_d        = idx_q + isr_pkg::IdxW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cmp_q   <= '0;
      pos_q   <= '0;
      idx_q   <= '0;
      in_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cmp_q   <= cmp_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      in_q    <= in_d;
    end
  end

`ifndef SYNTH
  a_no_rw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_req.we && st_req.re) |-> (st_req.waddr != st_req.raddr))
    else $error("store read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= isr_pkg::CntW'(isr_pkg::MaxRecords))
    else $error("record count above store depth");

  a_scan_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (pos_q != '0))
    else $error("scan running at position zero");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten while held");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_data.end_of_run) |=> (cnt_q == '0 && cmp_q == '0))
    else $error("counts not cleared after list end");
`endif

endmodule

@@ verif/isr_checker.sv @@
// ----------------------------------------------------------------------------
// isr_checker: result checker for the record insertion sorter
// Watches both channels, keeps its own sorted copy of the open list, and
// compares every emitted record with the predicted one in order.
// ----------------------------------------------------------------------------
module isr_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  isr_pkg::in_req_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  isr_pkg::out_req_t out_req_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o
);

  logic [isr_pkg::KeyW-1:0] held_key [isr_pkg::MaxRecords];
  logic [isr_pkg::IdW-1:0]  held_id  [isr_pkg::MaxRecords];
  int unsigned              held_count;
  logic [isr_pkg::CmpW-1:0] cmp_tally;
  isr_pkg::out_req_t        sorted_q [$];
  int unsigned              mismatches;

  // Insert one request into the predicted list; flush the list on its end.
  task automatic absorb_record(input isr_pkg::in_req_t rec);
    int unsigned       pos;
    bit                settled;
    isr_pkg::out_req_t entry;
    pos     = held_count;
    settled = 1'b0;
    while (pos > 0 && !settled) begin
      if (cmp_tally != isr_pkg::CmpMax) cmp_tally++;
      if (held_key[pos-1] > rec.sort_key) begin
        held_key[pos] = held_key[pos-1];
        held_id[pos]  = held_id[pos-1];
        pos--;
      end else begin
        settled = 1'b1;
      end
    end
    held_key[pos] = rec.sort_key;
    held_id[pos]  = rec.record_id;
    held_count++;
    if (rec.final_item || held_count >= isr_pkg::MaxRecords) begin
      for (int i = 0; i < held_count; i++) begin
        entry.sorted_key       = held_key[i];
        entry.sorted_id        = held_id[i];
        entry.comparison_total = cmp_tally;
        entry.end_of_run       = (i == held_count - 1);
        sorted_q = {sorted_q, entry};
      end
      held_count = 0;
      cmp_tally  = '0;
    end
  endtask

  task automatic check_result(input isr_pkg::out_req_t got);
    isr_pkg::out_req_t want;
    if (sorted_q.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected result key=%h id=%h cmp=%0d end=%b", $realtime,
                 got.sorted_key, got.sorted_id, got.comparison_total, got.end_of_run);
      mismatches++;
    end else begin
      want = sorted_q.pop_front();
      if (got.sorted_key !== want.sorted_key || got.sorted_id !== want.sorted_id ||
          got.comparison_total !== want.comparison_total ||
          got.end_of_run !== want.end_of_run) begin
        if (mismatches < 10)
          $display("%0t: mismatch exp key=%h id=%h cmp=%0d end=%b, got key=%h id=%h cmp=%0d end=%b",
                   $realtime, want.sorted_key, want.sorted_id, want.comparison_total,
                   want.end_of_run, got.sorted_key, got.sorted_id, got.comparison_total,
                   got.end_of_run);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      cmp_tally  = '0;
      mismatches = 0;
      sorted_q.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_req_i);
      if (in_valid_i && !in_stall_i) absorb_record(in_req_i);
      mismatch_count_o <= mismatches;
      pending_o        <= sorted_q.size();
    end
  end

endmodule

@@ verif/tb_insertion_sort_records_unit.sv @@
// ----------------------------------------------------------------------------
// tb_insertion_sort_records_unit: testbench of the record insertion sorter
// Sends lists of keyed records (directed edge cases, then random lists of
// mixed length and key shape, full stores among them) with random idle
// bursts on both channels; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_insertion_sort_records_unit;

  // Cycles without any accepted request before the run is declared hung.
  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned CalmFrom    = 430;

  typedef enum int {
    KEY_SPREAD,
    KEY_CLUSTER,
    KEY_FALLING,
    KEY_RISING
  } key_mix_e;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  isr_pkg::in_req_t  in_req    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  isr_pkg::out_req_t out_req;
  int unsigned       mismatch_count;
  int unsigned       pending;

  // Idle bursts are allowed only while this is set; cleared for the tail.
  logic        bursty    = 1'b0;
  int unsigned stall_left = 0;
  int unsigned items_sent = 0;
  int unsigned stuck_cycles = 0;

  always #5 clk = ~clk;

  insertion_sort_records_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  isr_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_req_i        (out_req),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Receiver side: hold stall for a random burst now and then, only while
  // bursts are allowed; finish a started burst regardless.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (bursty && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: count cycles with no accepted request on either channel.
  always @(posedge clk) begin
    if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall)) begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("tb_insertion_sort_records_unit: FAIL");
        $finish;
      end
    end else begin
      stuck_cycles = 0;
    end
  end

  // Offer one request and wait until it is accepted. An optional idle gap
  // goes first; valid gets exactly one assignment per edge, so a request
  // that follows another straight away keeps valid high.
  task automatic send_record(input logic [isr_pkg::KeyW-1:0] key,
                             input logic [isr_pkg::IdW-1:0] id,
                             input logic fin);
    if (bursty && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{sort_key: key, record_id: id, final_item: fin};
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Send a list of n records with keys of the given shape. With close_last
  // clear, the last record leaves final_item low (only useful for n = 64,
  // where the full store ends the list).
  task automatic send_list(input int unsigned n, input key_mix_e mix, input bit close_last);
    int unsigned start;
    int unsigned step;
    int unsigned key;
    start = $urandom_range(63000, 65535);
    step  = $urandom_range(0, 1000);
    if (mix == KEY_RISING) start = $urandom_range(0, 2000);
    if (mix == KEY_CLUSTER) start = $urandom & 16'hFFFC;
    for (int unsigned i = 0; i < n; i++) begin
      case (mix)
        KEY_SPREAD:  key = $urandom;
        KEY_CLUSTER: key = start | $urandom_range(0, 3);
        KEY_FALLING: key = start - i * step;
        default:     key = start + i * step;
      endcase
      send_record(isr_pkg::KeyW'(key), isr_pkg::IdW'($urandom), (i == n - 1) && close_last);
    end
  endtask

  // Drop valid and wait until every predicted result has been emitted.
  task automatic hold_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int unsigned n;
    bit          mid_drained;
    key_mix_e    mix;
    mid_drained = 1'b0;

    // Hold reset, then release it on an edge.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // Single-record lists at the field extremes: no comparisons at all.
    send_record(16'hFFFF, 16'hFFFF, 1'b1);
    send_record(16'h0000, 16'h0000, 1'b1);
    // Two records in reverse order: one comparison, one shift.
    send_record(16'hFFFF, 16'h0001, 1'b0);
    send_record(16'h0000, 16'hFFFE, 1'b1);
    // Equal keys throughout: order of arrival must survive.
    for (int i = 0; i < 5; i++) send_record(16'h8000, isr_pkg::IdW'(16'hA0 + i), i == 4);
    // Already ascending: each insertion stops at the first test.
    send_record(16'h0001, 16'h1111, 1'b0);
    send_record(16'h0100, 16'h2222, 1'b0);
    send_record(16'h7FFF, 16'h3333, 1'b0);
    send_record(16'hFFFE, 16'h4444, 1'b1);
    // Ties mixed with shifts: an equal key stops the scan.
    send_record(16'd5, 16'h0010, 1'b0);
    send_record(16'd3, 16'h0020, 1'b0);
    send_record(16'd5, 16'h0030, 1'b0);
    send_record(16'd1, 16'h0040, 1'b0);
    send_record(16'd3, 16'h0050, 1'b0);
    send_record(16'd5, 16'h0060, 1'b1);

    // Pause the sender until the directed lists have fully drained.
    hold_for_results();

    // ---- random part ----
    // Worst case first: 64 strictly falling keys, final_item never set, so
    // the full store ends the list with the largest comparison total.
    bursty <= 1'b1;
    for (int i = 0; i < 64; i++) begin
      send_record(isr_pkg::KeyW'(16'hFFFF - i), isr_pkg::IdW'($urandom), 1'b0);
    end

    while (items_sent < RandomItems) begin
      // Mix stretches with and without idle bursts; none in the tail.
      bursty <= (items_sent < CalmFrom) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 19) == 0)      n = 64;
      else if ($urandom_range(0, 5) == 0)  n = $urandom_range(13, 40);
      else                                 n = $urandom_range(1, 12);
      mix = key_mix_e'($urandom_range(0, 3));
      send_list(n, mix, (n < 64) || $urandom_range(0, 1));
      if (!mid_drained && items_sent >= RandomItems / 2) begin
        hold_for_results();
        mid_drained = 1'b1;
      end
    end

    // Let the last list drain, then allow a margin for stray results.
    bursty <= 1'b0;
    hold_for_results();
    repeat (100) @(posedge clk);

    if (mismatch_count == 0 && pending == 0) begin
      $display("tb_insertion_sort_records_unit: PASS");
    end else begin
      $display("tb_insertion_sort_records_unit: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/isr_pkg.sv
src/isr_store.sv
src/isr_out_reg.sv
src/insertion_sort_records_unit.sv
verif/isr_checker.sv
verif/tb_insertion_sort_records_unit.sv
